/* src/qwf_pkg.sv */
// Shared types and constants of the quietest window finder.
`default_nettype none
package qwf_pkg;

  // Width of the sample counter and of the reported start index.
  localparam int COUNT_W = 16;
  // The counter stops here; later samples are ignored.
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;
  // Width of the window length write word (cfg_data).
  localparam int CFG_W = 7;

  // Control word that travels with every sample from the front to the back.
  typedef struct packed {
    logic               eval;   // a full window ends at this sample
    logic               last;   // final sample of the sequence
    logic [COUNT_W-1:0] start;  // 1-based start of the window
  } qwf_item_t;

endpackage
`default_nettype wire

/* src/qwf_front.sv */
// Front part: window length register, sample window, counter and max/sum tree.
`default_nettype none
module qwf_front #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16,
  parameter int DATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8,
  parameter int SUM_W        = SAMPLE_WIDTH + $clog2(WINDOW_MAX),
  parameter int CREDITS      = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [qwf_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [DATA_W-1:0]          in_tdata,
  input  wire logic                       in_tlast,
  input  wire logic                       credit_return,
  output logic                            res_valid,
  output qwf_pkg::qwf_item_t              res_item,
  output logic [SAMPLE_WIDTH-1:0]         res_max,
  output logic [SUM_W-1:0]                res_sum
);
  import qwf_pkg::*;

  localparam int LEVELS = $clog2(WINDOW_MAX);
  localparam int NLEAF  = 1 << LEVELS;
  localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
  localparam int OCC_W  = $clog2(CREDITS + 1);

  logic [LEN_W-1:0]        len_r;
  logic [LEN_W-1:0]        len_nxt;
  logic [COUNT_W-1:0]      count_r;
  logic [COUNT_W-1:0]      count_inc;
  logic [OCC_W-1:0]        occ_r;
  logic [SAMPLE_WIDTH-1:0] window_r [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0] shifted  [NLEAF];
  logic [SAMPLE_WIDTH-1:0] hp_mx    [1:2*NLEAF-1];
  logic [SUM_W-1:0]        hp_sm    [1:2*NLEAF-1];
  logic [SAMPLE_WIDTH-1:0] node_mx_r [1:NLEAF-1];
  logic [SUM_W-1:0]        node_sm_r [1:NLEAF-1];
  logic                    pipe_vld_r  [LEVELS];
  qwf_item_t               pipe_item_r [LEVELS];
  qwf_item_t               new_item;
  logic                    accept;
  logic                    at_limit;

  assign cfg_ready = 1'b1;
  assign in_tready = (occ_r < OCC_W'(CREDITS));
  assign accept    = in_tvalid && in_tready;
  assign at_limit  = (count_r == COUNT_LIMIT);
  assign count_inc = count_r + COUNT_W'(1);

  // Length zero acts as one, lengths beyond the window store saturate.
  always_comb begin
    if (cfg_data == '0) begin
      len_nxt = LEN_W'(1);
    end else if (int'(cfg_data) > WINDOW_MAX) begin
      len_nxt = LEN_W'(WINDOW_MAX);
    end else begin
      len_nxt = LEN_W'(cfg_data);
    end
  end

  always_comb begin
    new_item.last  = in_tlast;
    new_item.eval  = !at_limit && (count_inc >= COUNT_W'(len_r));
    new_item.start = count_inc - COUNT_W'(len_r) + COUNT_W'(1);
  end

  // Window after the incoming sample is shifted in; entry 0 is the newest.
  always_comb begin
    for (int i = 0; i < NLEAF; i++) begin
      if (i == 0) begin
        shifted[i] = in_tdata[SAMPLE_WIDTH-1:0];
      end else if (i < WINDOW_MAX) begin
        shifted[i] = window_r[i-1];
      end else begin
        shifted[i] = '0;
      end
    end
  end

  // Heap view of the tree: internal nodes are registers, leaves are masked samples.
  always_comb begin
    for (int k = 1; k < 2 * NLEAF; k++) begin
      if (k < NLEAF) begin
        hp_mx[k] = node_mx_r[k];
        hp_sm[k] = node_sm_r[k];
      end else if ((k - NLEAF) < int'(len_r)) begin
        hp_mx[k] = shifted[k-NLEAF];
        hp_sm[k] = SUM_W'(shifted[k-NLEAF]);
      end else begin
        hp_mx[k] = '0;
        hp_sm[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k < NLEAF; k++) begin
      node_mx_r[k] <= (hp_mx[2*k] > hp_mx[2*k+1]) ? hp_mx[2*k] : hp_mx[2*k+1];
      node_sm_r[k] <= hp_sm[2*k] + hp_sm[2*k+1];
    end
    if (accept && !at_limit) begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
        window_r[i] <= shifted[i];
      end
    end
    pipe_item_r[0] <= new_item;
    for (int s = 1; s < LEVELS; s++) begin
      pipe_item_r[s] <= pipe_item_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= LEN_W'(1);
      count_r <= '0;
      occ_r   <= '0;
      for (int s = 0; s < LEVELS; s++) begin
        pipe_vld_r[s] <= 1'b0;
      end
    end else begin
      if (cfg_valid) begin
        len_r <= len_nxt;
      end
      if (accept) begin
        if (in_tlast) begin
          count_r <= '0;
        end else if (!at_limit) begin
          count_r <= count_inc;
        end
      end
      occ_r <= occ_r + OCC_W'(accept) - OCC_W'(credit_return);
      pipe_vld_r[0] <= accept;
      for (int s = 1; s < LEVELS; s++) begin
        pipe_vld_r[s] <= pipe_vld_r[s-1];
      end
    end
  end

  assign res_valid = pipe_vld_r[LEVELS-1];
  assign res_item  = pipe_item_r[LEVELS-1];
  assign res_max   = node_mx_r[1];
  assign res_sum   = node_sm_r[1];

endmodule
`default_nettype wire

/* src/qwf_fifo.sv */
// Short queue between the front and the back.
`default_nettype none
module qwf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  rvalid,
  output logic [WIDTH-1:0]      rdata
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign rvalid = (count_r != '0);
  assign rdata  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      count_r <= count_r + CW'(push) - CW'(pop);
    end
  end

endmodule
`default_nettype wire

/* src/qwf_back.sv */
// Back part: keeps the best window and drives the result register.
`default_nettype none
module qwf_back #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int SUM_W        = 22
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        head_valid,
  input  wire qwf_pkg::qwf_item_t          head_item,
  input  wire logic [SAMPLE_WIDTH-1:0]     head_max,
  input  wire logic [SUM_W-1:0]            head_sum,
  output logic                             pop,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [qwf_pkg::COUNT_W-1:0]      out_tdata,
  output logic                             out_tuser
);
  import qwf_pkg::*;

  logic                    have_best_r;
  logic [SAMPLE_WIDTH-1:0] best_max_r;
  logic [SUM_W-1:0]        best_sum_r;
  logic [COUNT_W-1:0]      best_idx_r;
  logic                    out_vld_r;
  logic [COUNT_W-1:0]      out_start_r;
  logic                    out_imp_r;
  logic                    better;
  logic                    slot_free;

  // A full window replaces the kept one on a lower max, or an equal max and lower sum.
  assign better = head_item.eval &&
                  (!have_best_r || (head_max < best_max_r) ||
                   ((head_max == best_max_r) && (head_sum < best_sum_r)));
  assign slot_free = !out_vld_r || out_tready;
  assign pop       = head_valid && (!head_item.last || slot_free);

  always_ff @(posedge clk) begin
    if (pop && head_item.last) begin
      out_imp_r   <= !(better || have_best_r);
      out_start_r <= better ? head_item.start : (have_best_r ? best_idx_r : '0);
    end
    if (pop && better) begin
      best_max_r <= head_max;
      best_sum_r <= head_sum;
      best_idx_r <= head_item.start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (pop && head_item.last) begin
        have_best_r <= 1'b0;
        out_vld_r   <= 1'b1;
      end else begin
        if (pop && better) begin
          have_best_r <= 1'b1;
        end
        if (out_tready) begin
          out_vld_r <= 1'b0;
        end
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_start_r;
  assign out_tuser  = out_imp_r;

endmodule
`default_nettype wire

/* src/quietest_window_finder.sv */
// Top level of the quietest window finder.
`default_nettype none
// The block takes one sample word per cycle and slides a window of cfg_data samples
// (1 to WINDOW_MAX; zero acts as one, larger values saturate) over the stream. For
// every full window it forms the maximum and the sum, and it keeps the window with the
// smallest maximum, then the smallest sum, then the earliest start. On the word marked
// by in_tlast it delivers one result word: the 1-based start of the kept window in
// out_tdata, or out_tuser set and a start of zero when no window was ever full. The
// stream then starts over; the window length keeps its value. Samples past index 65535
// are ignored, though a last mark on one still produces the result. Throughput is one
// sample per cycle while in_tready is high. A result passes the max and sum tree, which
// has one register stage per level, the first of them loaded by the edge that takes
// its last sample, then the queue and the output register. in_tready falls only when
// the queue and the tree together already hold log2(WINDOW_MAX) + 4 words, that is
// when the output side has stalled for a while. Write the window length only between
// streams or between samples with nothing in flight; cfg_ready is always high.
module quietest_window_finder #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // Window length register write.
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [qwf_pkg::CFG_W-1:0]              cfg_data,
  // Sample stream.
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      in_tdata,   // sample
  input  wire logic                                   in_tlast,
  // Result stream.
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  output logic [qwf_pkg::COUNT_W-1:0]                 out_tdata,  // best_start
  output logic                                        out_tuser   // impossible
);
  import qwf_pkg::*;

  localparam int DATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int LEVELS  = $clog2(WINDOW_MAX);
  localparam int SUM_W   = SAMPLE_WIDTH + LEVELS;
  // Queue depth covers every word that can be in the tree plus some slack.
  localparam int QDEPTH  = LEVELS + 4;
  localparam int QWIDTH  = $bits(qwf_item_t) + SAMPLE_WIDTH + SUM_W;

  logic                    res_valid;
  qwf_item_t               res_item;
  logic [SAMPLE_WIDTH-1:0] res_max;
  logic [SUM_W-1:0]        res_sum;
  logic                    q_valid;
  logic [QWIDTH-1:0]       q_data;
  logic                    q_pop;
  qwf_item_t               head_item;
  logic [SAMPLE_WIDTH-1:0] head_max;
  logic [SUM_W-1:0]        head_sum;

  // The front reads the window and classifies each sample; one credit per queue slot.
  qwf_front #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .DATA_W      (DATA_W),
    .SUM_W       (SUM_W),
    .CREDITS     (QDEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .credit_return(q_pop),
    .res_valid    (res_valid),
    .res_item     (res_item),
    .res_max      (res_max),
    .res_sum      (res_sum)
  );

  qwf_fifo #(
    .WIDTH(QWIDTH),
    .DEPTH(QDEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .wdata ({res_item, res_max, res_sum}),
    .pop   (q_pop),
    .rvalid(q_valid),
    .rdata (q_data)
  );

  assign {head_item, head_max, head_sum} = q_data;

  // The back compares each full window with the kept one and reports on the last word.
  qwf_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .SUM_W       (SUM_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(q_valid),
    .head_item (head_item),
    .head_max  (head_max),
    .head_sum  (head_sum),
    .pop       (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
`default_nettype wire
